[rtl/core/dmf_pkg.sv]
`timescale 1ns / 1ps

package dmf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COL_LIMIT     = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W  = 8;
  localparam int RGB_W  = 3 * PIX_W;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int SUM_W  = 10;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // floor(x / 3) for x up to 765 equals (x * 683) >> 11.
  localparam int RECIP       = 683;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W      = 20;

  typedef struct packed {
    logic             has_a;
    logic             has_b;
    logic             done;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [RGB_W-1:0] a_rgb;
    logic [RGB_W-1:0] b_rgb;
  } dmf_entry_t;

  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(RECIP);
    return prod[RECIP_SHIFT +: PIX_W];
  endfunction

endpackage

[rtl/core/dmf_line_bank.sv]
`timescale 1ns / 1ps

module dmf_line_bank #(
  parameter int DEPTH = dmf_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [dmf_pkg::RGB_W-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [dmf_pkg::RGB_W-1:0]  rdata
);

  logic [dmf_pkg::RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dmf_lane.sv]
`timescale 1ns / 1ps

module dmf_lane (
  input  logic [dmf_pkg::PIX_W-1:0] up,
  input  logic [dmf_pkg::PIX_W-1:0] mid,
  input  logic [dmf_pkg::PIX_W-1:0] px,
  input  logic                      up_ok,
  input  logic                      mid_ok,
  output logic [dmf_pkg::PIX_W-1:0] a_val,
  output logic [dmf_pkg::PIX_W-1:0] b_val
);

  logic [dmf_pkg::SUM_W-1:0] sum_a;
  logic [dmf_pkg::SUM_W-1:0] sum_b;

  always_comb begin
    sum_a = (up_ok ? dmf_pkg::SUM_W'(up) : '0) + dmf_pkg::SUM_W'(mid)
          + dmf_pkg::SUM_W'(px);
    sum_b = (mid_ok ? dmf_pkg::SUM_W'(mid) : '0) + dmf_pkg::SUM_W'(px);
    a_val = dmf_pkg::div3(sum_a);
    b_val = dmf_pkg::div3(sum_b);
  end

endmodule

[rtl/core/dmf_result_queue.sv]
`timescale 1ns / 1ps

module dmf_result_queue #(
  parameter int DEPTH = dmf_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dmf_pkg::dmf_entry_t           push_entry,
  output logic [$clog2(DEPTH+1)-1:0]    count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dmf_pkg::ROW_W-1:0]     out_row,
  output logic [dmf_pkg::COL_W-1:0]     out_col,
  output logic [dmf_pkg::PIX_W-1:0]     out_red,
  output logic [dmf_pkg::PIX_W-1:0]     out_green,
  output logic [dmf_pkg::PIX_W-1:0]     out_blue,
  output logic                          frame_done
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam int RGB_W_L = dmf_pkg::RGB_W;

  dmf_pkg::dmf_entry_t entries [DEPTH];
  dmf_pkg::dmf_entry_t head;

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          sel;
  logic          showing_a;
  logic          take;
  logic          pop;

  logic [RGB_W_L-1:0] rgb;

  assign head      = entries[rd_ptr];
  assign out_valid = (count != '0);
  assign showing_a = head.has_a && !sel;
  assign take      = out_valid && !out_stall;
  assign pop       = take && !(showing_a && head.has_b);

  always_comb begin
    if (showing_a) begin
      out_row    = head.row - dmf_pkg::ROW_W'(1);
      out_col    = head.col - dmf_pkg::COL_W'(1);
      rgb        = head.a_rgb;
      frame_done = 1'b0;
    end else begin
      out_row    = head.row;
      out_col    = head.col;
      rgb        = head.b_rgb;
      frame_done = head.done;
    end
    out_red   = rgb[2*dmf_pkg::PIX_W +: dmf_pkg::PIX_W];
    out_green = rgb[dmf_pkg::PIX_W +: dmf_pkg::PIX_W];
    out_blue  = rgb[0 +: dmf_pkg::PIX_W];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
        sel    <= 1'b0;
      end else if (take) begin
        sel <= 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

[rtl/core/diagonal_motion_filter_3x3.sv]
`timescale 1ns / 1ps

// Diagonal 3x3 motion filter for a raster-order RGB stream. Each result is the floor of the
// sum of the pixel and its upper-left and lower-right neighbors divided by three, with
// neighbors outside the frame taken as zero, and carries its row and column. Results leave
// as soon as their last input has arrived, at most two per pixel. Inside the frame a pixel is
// accepted every clock while the result queue has room. Every pixel of the last row after
// the first yields two results while the result port moves one transaction per clock when
// not stalled, so once the four-entry result queue fills the last row is accepted more
// slowly. A pixel passes the input registers and the result queue before its first result
// can leave. A three-row line store built from three single-write, single-read banks of
// MAX_WIDTH entries keeps the recent rows; it needs no clearing after reset. A write to
// either size register restarts the frame.
module diagonal_motion_filter_3x3 #(
  parameter int MAX_WIDTH = dmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmf_pkg::ADDR_W-1:0]    paddr,
  input  logic [dmf_pkg::DATA_W-1:0]    pwdata,
  output logic [dmf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dmf_pkg::PIX_W-1:0]     in_red,
  input  logic [dmf_pkg::PIX_W-1:0]     in_green,
  input  logic [dmf_pkg::PIX_W-1:0]     in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dmf_pkg::ROW_W-1:0]     out_row,
  output logic [dmf_pkg::COL_W-1:0]     out_col,
  output logic [dmf_pkg::PIX_W-1:0]     out_red,
  output logic [dmf_pkg::PIX_W-1:0]     out_green,
  output logic [dmf_pkg::PIX_W-1:0]     out_blue,
  output logic                          frame_done
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(dmf_pkg::QUEUE_DEPTH + 1);
  localparam logic [dmf_pkg::WID_W-1:0] WLIM =
    dmf_pkg::WID_W'(MAX_WIDTH < dmf_pkg::COL_LIMIT ? MAX_WIDTH : dmf_pkg::COL_LIMIT);
  localparam logic [dmf_pkg::HGT_W-1:0] HLIM = dmf_pkg::HGT_W'(dmf_pkg::MAX_HEIGHT);

  logic [dmf_pkg::WID_W-1:0] image_width;
  logic [dmf_pkg::HGT_W-1:0] image_height;
  logic [dmf_pkg::ROW_W-1:0] row_position;
  logic [dmf_pkg::COL_W-1:0] col_position;
  logic [1:0]                bank;

  logic cfg_write;
  logic accept;
  logic [dmf_pkg::WID_W-1:0] w_eff;
  logic [dmf_pkg::HGT_W-1:0] h_eff;
  logic [dmf_pkg::COL_W-1:0] w_last;
  logic [dmf_pkg::ROW_W-1:0] h_last;
  logic last_col;
  logic last_row;
  logic [1:0] mid_bank;
  logic [1:0] up_bank;
  logic [dmf_pkg::RGB_W-1:0] px;

  logic                       v1;
  logic [dmf_pkg::ROW_W-1:0]  row1;
  logic [dmf_pkg::COL_W-1:0]  col1;
  logic [dmf_pkg::RGB_W-1:0]  px1;
  logic                       has_a1;
  logic                       has_b1;
  logic                       done1;
  logic                       up_ok1;
  logic [1:0]                 up_bank1;
  logic [1:0]                 mid_bank1;

  logic [dmf_pkg::RGB_W-1:0]  rdata [3];
  logic [dmf_pkg::RGB_W-1:0]  up_d;
  logic [dmf_pkg::RGB_W-1:0]  mid_d;
  logic [dmf_pkg::RGB_W-1:0]  a_rgb;
  logic [dmf_pkg::RGB_W-1:0]  b_rgb;

  dmf_pkg::dmf_entry_t push_entry;
  logic                push;
  logic [CW-1:0]       count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (count + CW'(v1)) >= CW'(dmf_pkg::QUEUE_DEPTH);
  assign px        = {in_red, in_green, in_blue};

  always_comb begin
    case (paddr[2])
      dmf_pkg::REG_WIDTH:  prdata = dmf_pkg::DATA_W'(image_width);
      dmf_pkg::REG_HEIGHT: prdata = dmf_pkg::DATA_W'(image_height);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = dmf_pkg::WID_W'(1);
    end else if (image_width > WLIM) begin
      w_eff = WLIM;
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = dmf_pkg::HGT_W'(1);
    end else if (image_height > HLIM) begin
      h_eff = HLIM;
    end else begin
      h_eff = image_height;
    end
    w_last   = dmf_pkg::COL_W'(w_eff - dmf_pkg::WID_W'(1));
    h_last   = dmf_pkg::ROW_W'(h_eff - dmf_pkg::HGT_W'(1));
    last_col = (col_position == w_last);
    last_row = (row_position == h_last);
    mid_bank = (bank == 2'd0) ? 2'd2 : bank - 2'd1;
    up_bank  = (bank == 2'd2) ? 2'd0 : bank + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dmf_pkg::WIDTH_RST;
      image_height <= dmf_pkg::HEIGHT_RST;
      row_position <= '0;
      col_position <= '0;
      bank         <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        dmf_pkg::REG_WIDTH:  image_width  <= pwdata[dmf_pkg::WID_W-1:0];
        dmf_pkg::REG_HEIGHT: image_height <= pwdata[dmf_pkg::HGT_W-1:0];
        default:             image_width  <= image_width;
      endcase
      row_position <= '0;
      col_position <= '0;
      bank         <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_position <= '0;
        if (last_row) begin
          row_position <= '0;
          bank         <= '0;
        end else begin
          row_position <= row_position + dmf_pkg::ROW_W'(1);
          bank         <= up_bank;
        end
      end else begin
        col_position <= col_position + dmf_pkg::COL_W'(1);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_bank
    logic [AW-1:0] raddr;
    assign raddr = (mid_bank == 2'(j)) ? AW'(col_position - dmf_pkg::COL_W'(1))
                                       : AW'(col_position - dmf_pkg::COL_W'(2));
    dmf_line_bank #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .we    (accept && (bank == 2'(j))),
      .waddr (AW'(col_position)),
      .wdata (px),
      .raddr (raddr),
      .rdata (rdata[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row1      <= row_position;
      col1      <= col_position;
      px1       <= px;
      has_a1    <= (row_position != '0) && (col_position != '0);
      has_b1    <= last_row || last_col;
      done1     <= last_row && last_col;
      up_ok1    <= (row_position >= dmf_pkg::ROW_W'(2)) && (col_position >= dmf_pkg::COL_W'(2));
      up_bank1  <= up_bank;
      mid_bank1 <= mid_bank;
    end
  end

  assign up_d  = rdata[up_bank1];
  assign mid_d = rdata[mid_bank1];

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    dmf_lane u_lane (
      .up     (up_d[ch*dmf_pkg::PIX_W +: dmf_pkg::PIX_W]),
      .mid    (mid_d[ch*dmf_pkg::PIX_W +: dmf_pkg::PIX_W]),
      .px     (px1[ch*dmf_pkg::PIX_W +: dmf_pkg::PIX_W]),
      .up_ok  (up_ok1),
      .mid_ok (has_a1),
      .a_val  (a_rgb[ch*dmf_pkg::PIX_W +: dmf_pkg::PIX_W]),
      .b_val  (b_rgb[ch*dmf_pkg::PIX_W +: dmf_pkg::PIX_W])
    );
  end

  assign push = v1 && (has_a1 || has_b1);

  always_comb begin
    push_entry.has_a = has_a1;
    push_entry.has_b = has_b1;
    push_entry.done  = done1;
    push_entry.row   = row1;
    push_entry.col   = col1;
    push_entry.a_rgb = a_rgb;
    push_entry.b_rgb = b_rgb;
  end

  dmf_result_queue #(
    .DEPTH (dmf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .count      (count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_done (frame_done)
  );

endmodule

[rtl/core/dmf_checker.sv]
`timescale 1ns / 1ps

module dmf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dmf_pkg::ROW_W-1:0]     out_row,
  input logic [dmf_pkg::COL_W-1:0]     out_col,
  input logic [dmf_pkg::PIX_W-1:0]     out_red,
  input logic [dmf_pkg::PIX_W-1:0]     out_green,
  input logic [dmf_pkg::PIX_W-1:0]     out_blue,
  input logic                          frame_done
);

  // After reset the block holds no transaction and takes input at once.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // A result can only appear as the consequence of an earlier input transaction.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_row) && $stable(out_col) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(frame_done))
    else $error("stalled result changed");

endmodule

bind diagonal_motion_filter_3x3 dmf_checker u_dmf_checker (.*);

[tb/sv/diagonal_motion_filter_3x3_tb.sv]
`timescale 1ns / 1ps

module diagonal_motion_filter_3x3_tb;

  localparam int STORE_COLS   = dmf_pkg::MAX_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 350;

  typedef struct packed {
    logic [dmf_pkg::ROW_W-1:0] row;
    logic [dmf_pkg::COL_W-1:0] col;
    logic [dmf_pkg::PIX_W-1:0] red;
    logic [dmf_pkg::PIX_W-1:0] green;
    logic [dmf_pkg::PIX_W-1:0] blue;
    logic                      done;
  } filt_pix_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [dmf_pkg::ADDR_W-1:0] paddr     = '0;
  logic [dmf_pkg::DATA_W-1:0] pwdata    = '0;
  logic [dmf_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [dmf_pkg::PIX_W-1:0]  in_red    = '0;
  logic [dmf_pkg::PIX_W-1:0]  in_green  = '0;
  logic [dmf_pkg::PIX_W-1:0]  in_blue   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [dmf_pkg::ROW_W-1:0]  out_row;
  logic [dmf_pkg::COL_W-1:0]  out_col;
  logic [dmf_pkg::PIX_W-1:0]  out_red;
  logic [dmf_pkg::PIX_W-1:0]  out_green;
  logic [dmf_pkg::PIX_W-1:0]  out_blue;
  logic                       frame_done;

  filt_pix_t                  expected_pix[$];
  logic [dmf_pkg::RGB_W-1:0]  line_mem [0:3*STORE_COLS-1];
  logic [dmf_pkg::WID_W-1:0]  cfg_width  = dmf_pkg::WIDTH_RST;
  logic [dmf_pkg::HGT_W-1:0]  cfg_height = dmf_pkg::HEIGHT_RST;
  int unsigned                pos_row    = 0;
  int unsigned                pos_col    = 0;

  int unsigned       fail_count  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       rx_hold     = 0;
  bit                tx_idle     = 1'b1;
  bit                rx_idle     = 1'b1;

  diagonal_motion_filter_3x3 dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_done (frame_done)
  );

  always #5 clk = ~clk;

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic int unsigned active_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > dmf_pkg::COL_LIMIT) return dmf_pkg::COL_LIMIT;
    return cfg_width;
  endfunction

  function automatic int unsigned active_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > dmf_pkg::MAX_HEIGHT) return dmf_pkg::MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic filt_pix_t blend(input int unsigned row, input int unsigned col,
                                      input logic [dmf_pkg::RGB_W-1:0] a,
                                      input logic [dmf_pkg::RGB_W-1:0] b,
                                      input logic [dmf_pkg::RGB_W-1:0] c, input logic done);
    filt_pix_t   p;
    int unsigned s_r;
    int unsigned s_g;
    int unsigned s_b;
    s_r = a[23:16] + b[23:16] + c[23:16];
    s_g = a[15:8] + b[15:8] + c[15:8];
    s_b = a[7:0] + b[7:0] + c[7:0];
    p.row   = dmf_pkg::ROW_W'(row);
    p.col   = dmf_pkg::COL_W'(col);
    p.red   = dmf_pkg::PIX_W'(s_r / 3);
    p.green = dmf_pkg::PIX_W'(s_g / 3);
    p.blue  = dmf_pkg::PIX_W'(s_b / 3);
    p.done  = done;
    return p;
  endfunction

  task automatic predict_filter(input logic [dmf_pkg::RGB_W-1:0] px);
    int unsigned               w;
    int unsigned               h;
    int unsigned               r;
    int unsigned               c;
    logic [dmf_pkg::RGB_W-1:0] up;
    logic [dmf_pkg::RGB_W-1:0] mid;
    w = active_width();
    h = active_height();
    r = pos_row;
    c = pos_col;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    line_mem[(r % 3) * STORE_COLS + c] = px;
    if (r >= 1 && c >= 1) begin
      up  = (r >= 2 && c >= 2) ? line_mem[((r - 2) % 3) * STORE_COLS + c - 2] : '0;
      mid = line_mem[((r - 1) % 3) * STORE_COLS + c - 1];
      expected_pix.push_back(blend(r - 1, c - 1, up, mid, px, 1'b0));
    end
    if (r == h - 1 || c == w - 1) begin
      up = (r >= 1 && c >= 1) ? line_mem[((r - 1) % 3) * STORE_COLS + c - 1] : '0;
      expected_pix.push_back(blend(r, c, up, px, '0, (r == h - 1) && (c == w - 1)));
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endtask

  task automatic set_idling(input bit tx, input bit rx);
    tx_idle = tx;
    rx_idle = rx;
  endtask

  task automatic send_pixel(input logic [dmf_pkg::RGB_W-1:0] px);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px[23:16];
    in_green <= px[15:8];
    in_blue  <= px[7:0];
    do @(posedge clk); while (in_stall);
    predict_filter(px);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [dmf_pkg::DATA_W-1:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == dmf_pkg::REG_WIDTH) begin
      cfg_width = data[dmf_pkg::WID_W-1:0];
    end else begin
      cfg_height = data[dmf_pkg::HGT_W-1:0];
    end
    pos_row = 0;
    pos_col = 0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [dmf_pkg::DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      note_fail($sformatf("register %0d read: expected %0d, got %0d", idx, want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(dmf_pkg::REG_WIDTH, dmf_pkg::DATA_W'(w));
    write_reg(dmf_pkg::REG_HEIGHT, dmf_pkg::DATA_W'(h));
    check_reg(dmf_pkg::REG_WIDTH, dmf_pkg::DATA_W'(w));
    check_reg(dmf_pkg::REG_HEIGHT, dmf_pkg::DATA_W'(h));
  endtask

  task automatic test_reset_state();
    check_reg(dmf_pkg::REG_WIDTH, dmf_pkg::DATA_W'(dmf_pkg::WIDTH_RST));
    check_reg(dmf_pkg::REG_HEIGHT, dmf_pkg::DATA_W'(dmf_pkg::HEIGHT_RST));
    repeat (3) send_pixel(dmf_pkg::RGB_W'($urandom));
  endtask

  task automatic test_channel_extremes();
    logic [dmf_pkg::RGB_W-1:0] pattern [9];
    pattern = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'hFFFFFF, 24'hAA55AA,
                24'h55AA55, 24'hFF00FF, 24'hFFFFFF};
    set_size(3, 3);
    foreach (pattern[i]) send_pixel(pattern[i]);
  endtask

  task automatic test_zero_size();
    set_size(0, 0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h010203);
  endtask

  task automatic test_single_row();
    set_size(5, 1);
    repeat (5) send_pixel(dmf_pkg::RGB_W'($urandom));
  endtask

  task automatic test_single_column();
    set_size(1, 3);
    repeat (3) send_pixel(dmf_pkg::RGB_W'($urandom));
  endtask

  task automatic test_widest_rows();
    set_idling(1'b0, 1'b0);
    set_size(2047, 1);
    repeat (1025) send_pixel(dmf_pkg::RGB_W'($urandom));
  endtask

  task automatic test_tallest_frame();
    set_idling(1'b0, 1'b0);
    set_size(1, 8191);
    repeat (64) send_pixel(dmf_pkg::RGB_W'($urandom));
  endtask

  task automatic test_random_frames();
    int unsigned total;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(17, 64);
        default: w = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = $urandom_range(11, 40);
        default: h = $urandom_range(1, 10);
      endcase
      if (w > 16) h = $urandom_range(1, 4);
      set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      // A lone width write must also restart the frame.
      write_reg(dmf_pkg::REG_WIDTH, dmf_pkg::DATA_W'(w));
      if ($urandom_range(0, 3) != 0) write_reg(dmf_pkg::REG_HEIGHT, dmf_pkg::DATA_W'(h));
      n = active_width() * active_height();
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, n);
      end else begin
        n = n * $urandom_range(1, 2);
      end
      if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
      repeat (n) send_pixel(dmf_pkg::RGB_W'($urandom));
      total += n;
    end
  endtask

  always @(posedge clk) begin
    filt_pix_t got;
    filt_pix_t want;
    if (!rst && out_valid && !out_stall) begin
      got.row   = out_row;
      got.col   = out_col;
      got.red   = out_red;
      got.green = out_green;
      got.blue  = out_blue;
      got.done  = frame_done;
      if (expected_pix.size() == 0) begin
        note_fail($sformatf("unexpected result at row %0d col %0d", out_row, out_col));
      end else begin
        want = expected_pix.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue || got.done !== want.done) begin
          note_fail($sformatf({"mismatch: expected row %0d col %0d rgb %0d/%0d/%0d done %0b,",
                               " got row %0d col %0d rgb %0d/%0d/%0d done %0b"},
                              want.row, want.col, want.red, want.green, want.blue, want.done,
                              got.row, got.col, got.red, got.green, got.blue, got.done));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      rx_hold = rx_idle ? $urandom_range(0, 9) : 0;
    end else if (rx_hold != 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold != 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL diagonal_motion_filter_3x3");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_channel_extremes();
    test_zero_size();
    test_single_row();
    test_single_column();
    test_widest_rows();
    test_tallest_frame();
    test_random_frames();
    in_valid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS diagonal_motion_filter_3x3");
    end else begin
      $display("FAIL diagonal_motion_filter_3x3");
    end
    $finish;
  end

endmodule
